/* rtl/pls_pkg.sv */
// Package: shared constants, codes and types for the piecewise linear scaler
`default_nettype none
package pls_pkg;
    localparam int MAX_POINTS = 8;
    localparam int FRAC_BITS  = 16;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int DATA_W     = 32;
    localparam int CNT_W      = 4;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_SCALING_ON  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_CURVE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT = 3'd4;

    localparam logic [2:0] REG_BYPASS = 3'd0;
    localparam logic [2:0] REG_LINEAR = 3'd1;
    localparam logic [2:0] REG_INTERP = 3'd2;
    localparam logic [2:0] REG_CLAMP  = 3'd3;
    localparam logic [2:0] REG_LINSAT = 3'd4;

    typedef enum logic [1:0] {
        K_BYPASS,
        K_LINEAR,
        K_CLAMP,
        K_INTERP
    } t_kind;

    // classified work handed from front to back
    typedef struct packed {
        t_kind              kind;
        logic signed [31:0] x;
        logic signed [31:0] lo_in;
        logic signed [31:0] lo_out;
        logic signed [31:0] hi_in;
        logic signed [31:0] hi_out;
    } t_job;
endpackage
`default_nettype wire

/* rtl/pls_in_if.sv */
// Interface: input channel of the scaler
`default_nettype none
interface pls_in_if;
    logic               valid;
    logic               ready;
    logic               command;
    logic signed [31:0] sample_value;
    logic [2:0]         point_index;
    logic signed [31:0] point_in;
    logic signed [31:0] point_out;
    modport source (output valid, command, sample_value, point_index, point_in,
                    point_out, input ready);
    modport sink (input valid, command, sample_value, point_index, point_in,
                  point_out, output ready);
endinterface
`default_nettype wire

/* rtl/pls_out_if.sv */
// Interface: result channel of the scaler
`default_nettype none
interface pls_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] scaled_value;
    logic [2:0]         region;
    modport source (output valid, scaled_value, region, input ready);
    modport sink (input valid, scaled_value, region, output ready);
endinterface
`default_nettype wire

/* rtl/pls_front.sv */
// Front end: curve store, point writes and segment search
`default_nettype none
module pls_front import pls_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic               i_command,
    input  wire logic signed [31:0] i_sample_value,
    input  wire logic [2:0]         i_point_index,
    input  wire logic signed [31:0] i_point_in,
    input  wire logic signed [31:0] i_point_out,
    input  wire logic               i_scaling_on,
    input  wire logic               i_use_curve,
    input  wire logic [CNT_W-1:0]   i_point_count,
    input  wire logic               i_q_full,
    output logic                    o_push,
    output t_job                    o_job
);
    logic signed [31:0] r_cin  [MAX_POINTS];
    logic signed [31:0] r_cout [MAX_POINTS];
    logic [MAX_POINTS-1:0] below;
    logic [CNT_W-1:0] n;
    logic [IDX_W:0] seg;
    logic [IDX_W-1:0] lo_i, hi_i, last_i;
    logic fire;

    assign o_ready = !i_q_full;
    assign fire    = i_valid && o_ready;
    assign n = (i_point_count > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : i_point_count;

    always_ff @(posedge i_clk) begin
        if (fire && i_command && ({1'b0, i_point_index} < 4'(MAX_POINTS))) begin
            r_cin[i_point_index[IDX_W-1:0]]  <= i_point_in;
            r_cout[i_point_index[IDX_W-1:0]] <= i_point_out;
        end
    end

    // parallel compares; the first point above the value ends the search
    always_comb begin
        for (int k = 0; k < MAX_POINTS; k++)
            below[k] = (CNT_W'(k) < n) && (i_sample_value < r_cin[k]);
        seg = (IDX_W+1)'(n);
        for (int k = MAX_POINTS - 1; k >= 0; k--)
            if (below[k]) seg = (IDX_W+1)'(k);
    end

    assign hi_i   = seg[IDX_W-1:0];
    assign lo_i   = seg[IDX_W-1:0] - 1'b1;
    assign last_i = IDX_W'(n - 1'b1);

    always_comb begin
        o_push = fire && !i_command;
        o_job.x      = i_sample_value;
        o_job.lo_in  = r_cin[lo_i];
        o_job.lo_out = r_cout[lo_i];
        o_job.hi_in  = r_cin[hi_i];
        o_job.hi_out = r_cout[hi_i];
        if (!i_scaling_on) begin
            o_job.kind = K_BYPASS;
        end else if (!i_use_curve || n < CNT_W'(2)) begin
            o_job.kind = K_LINEAR;
        end else if (seg == '0) begin
            o_job.kind   = K_CLAMP;
            o_job.lo_out = r_cout[0];
        end else if (seg >= (IDX_W+1)'(n)) begin
            o_job.kind   = K_CLAMP;
            o_job.lo_out = r_cout[last_i];
        end else begin
            o_job.kind = K_INTERP;
        end
    end
endmodule
`default_nettype wire

/* rtl/pls_queue.sv */
// Two-entry queue between the front and back ends
`default_nettype none
module pls_queue import pls_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_job      i_job,
    output logic      o_full,
    output logic      o_empty,
    input  wire logic i_pop,
    output t_job      o_job
);
    t_job r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = r_cnt == 2'd2;
    assign o_empty = r_cnt == 2'd0;
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
        if (i_push) r_mem[r_wp] <= i_job;
    end
endmodule
`default_nettype wire

/* rtl/pls_back.sv */
// Back end: linear arithmetic and bit-serial interpolation divide
`default_nettype none
module pls_back import pls_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_q_empty,
    output logic                    o_pop,
    input  t_job                    i_job,
    input  wire logic signed [31:0] i_gain,
    input  wire logic signed [31:0] i_offset,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic signed [31:0]      o_scaled_value,
    output logic [2:0]              o_region
);
    typedef enum logic [2:0] {S_IDLE, S_MUL, S_LIN, S_IMUL, S_DIV, S_FIN, S_OUT} t_state;
    localparam int DW = 66;  // dividend width: product plus rounding
    t_state r_state;
    t_job   r_job;
    logic signed [63:0] r_prod;
    logic [DW-1:0]      r_num;
    logic [32:0]        r_rem;
    logic [32:0]        r_span;
    logic [6:0]         r_cnt;
    logic               r_neg;
    logic signed [32:0] r_dy;
    logic [31:0]        r_dx;

    logic signed [64:0] lin_t;
    logic signed [65:0] lin_s;
    logic signed [32:0] dx_w, sp_w, dy_w;
    logic [32:0]        trial;
    logic [32:0]        rem_sh;
    logic [32:0]        dy_mag;

    assign o_pop  = (r_state == S_IDLE) && !i_q_empty;
    assign lin_t  = (65'(r_prod) + 65'(64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    assign lin_s  = 66'(lin_t) + 66'(i_offset);
    assign dx_w   = 33'(r_job.x) - 33'(r_job.lo_in);
    assign sp_w   = 33'(r_job.hi_in) - 33'(r_job.lo_in);
    assign dy_w   = 33'(r_job.hi_out) - 33'(r_job.lo_out);
    assign dy_mag = r_dy[32] ? 33'(-r_dy) : 33'(r_dy);
    assign rem_sh = {r_rem[31:0], r_num[DW-1]};
    assign trial  = rem_sh - r_span;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: if (!i_q_empty) begin
                    r_job   <= i_job;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod <= 64'(r_job.x) * 64'(i_gain);
                    r_span <= 33'(sp_w);
                    r_dx   <= dx_w[31:0];
                    r_dy   <= dy_w;
                    unique case (r_job.kind)
                        K_BYPASS: begin
                            o_scaled_value <= r_job.x; o_region <= REG_BYPASS;
                            r_state <= S_OUT;
                        end
                        K_CLAMP: begin
                            o_scaled_value <= r_job.lo_out; o_region <= REG_CLAMP;
                            r_state <= S_OUT;
                        end
                        K_LINEAR: r_state <= S_LIN;
                        K_INTERP: r_state <= S_IMUL;
                        default:  r_state <= S_OUT;
                    endcase
                end
                S_LIN: begin
                    if (lin_s > 66'sd2147483647) begin
                        o_scaled_value <= 32'sh7fffffff; o_region <= REG_LINSAT;
                    end else if (lin_s < -66'sd2147483648) begin
                        o_scaled_value <= 32'sh80000000; o_region <= REG_LINSAT;
                    end else begin
                        o_scaled_value <= lin_s[31:0]; o_region <= REG_LINEAR;
                    end
                    r_state <= S_OUT;
                end
                S_IMUL: begin
                    if (sp_w <= 0) begin
                        o_scaled_value <= r_job.lo_out; o_region <= REG_INTERP;
                        r_state <= S_OUT;
                    end else begin
                        r_num <= DW'({32'd0, r_dx} * {31'd0, dy_mag}) + DW'(r_span >> 1);
                        r_neg <= r_dy[32];
                        r_rem <= '0;
                        r_cnt <= 7'(DW);
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    // one quotient bit a cycle, restoring
                    if (trial[32] == 1'b0 && rem_sh >= r_span) begin
                        r_rem <= trial;
                        r_num <= {r_num[DW-2:0], 1'b1};
                    end else begin
                        r_rem <= rem_sh;
                        r_num <= {r_num[DW-2:0], 1'b0};
                    end
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == 7'd1) r_state <= S_FIN;
                end
                S_FIN: begin
                    o_scaled_value <= r_neg ? r_job.lo_out - r_num[31:0]
                                            : r_job.lo_out + r_num[31:0];
                    o_region <= REG_INTERP;
                    r_state  <= S_OUT;
                end
                S_OUT: begin
                    if (!o_valid) o_valid <= 1'b1;
                    else if (i_ready) begin
                        o_valid <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

/* rtl/piecewise_linear_scaler.sv */
// Top level: piecewise linear scaler with decoupled search and arithmetic
// Usage:
//  - Input channel (pls_in_if): a beat with command 1 writes a curve point
//    and yields no result; command 0 converts sample_value.
//  - Output channel (pls_out_if): one beat per convert, scaled_value and region.
//  - Config port: write enable, register index, 32-bit data; write only idle.
//  - The front end searches the stored curve in the cycle a beat is taken and
//    pushes the chosen segment into a two-entry queue; writes finish there.
//  - The back end handles one item at a time and takes the next one only
//    after the result beat is accepted. Bypass and clamp pass S_MUL, S_OUT;
//    linear adds S_LIN; interpolation adds S_IMUL, the 66-step bit-serial
//    divider and S_FIN, and the divider sets the throughput.
//  - Point writes are accepted each cycle while the queue has room.
//  - If the receiver stalls the result holds; the queue fills, then ready drops.
//  - Reset clears config to defaults and empties queue and output; curve
//    contents are undefined until written.
`default_nettype none
module piecewise_linear_scaler import pls_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    pls_in_if.sink                    in_ch,
    pls_out_if.source                 out_ch,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [31:0]          i_cfg_data
);
    logic r_scaling_on, r_use_curve;
    logic signed [31:0] r_gain, r_offset;
    logic [CNT_W-1:0] r_point_count;
    logic q_full, q_empty, push, pop;
    t_job f_job, b_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scaling_on <= 1'b0; r_use_curve <= 1'b0;
            r_gain <= 32'sd65536; r_offset <= '0; r_point_count <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SCALING_ON:  r_scaling_on  <= i_cfg_data[0];
                CFG_USE_CURVE:   r_use_curve   <= i_cfg_data[0];
                CFG_GAIN:        r_gain        <= i_cfg_data;
                CFG_OFFSET:      r_offset      <= i_cfg_data;
                CFG_POINT_COUNT: r_point_count <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    pls_front u_front (
        .i_clk, .i_valid(in_ch.valid), .o_ready(in_ch.ready),
        .i_command(in_ch.command), .i_sample_value(in_ch.sample_value),
        .i_point_index(in_ch.point_index), .i_point_in(in_ch.point_in),
        .i_point_out(in_ch.point_out), .i_scaling_on(r_scaling_on),
        .i_use_curve(r_use_curve), .i_point_count(r_point_count),
        .i_q_full(q_full), .o_push(push), .o_job(f_job)
    );

    pls_queue u_queue (
        .i_clk, .i_rst_n, .i_push(push), .i_job(f_job), .o_full(q_full),
        .o_empty(q_empty), .i_pop(pop), .o_job(b_job)
    );

    pls_back u_back (
        .i_clk, .i_rst_n, .i_q_empty(q_empty), .o_pop(pop), .i_job(b_job),
        .i_gain(r_gain), .i_offset(r_offset), .o_valid(out_ch.valid),
        .i_ready(out_ch.ready), .o_scaled_value(out_ch.scaled_value),
        .o_region(out_ch.region)
    );

    // hold no beat into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_full |-> !push) else $error("push into full queue");
    // region code stays within its defined set
    a_region: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid |-> (out_ch.region <= REG_LINSAT)) else $error("bad region");
    // a stalled result holds its value
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid && !out_ch.ready |=> $stable(out_ch.scaled_value))
        else $error("result changed under stall");
endmodule
`default_nettype wire
